// ===== sv/bfmd_pkg.sv =====
// Shared types and constants for the 2x2 box-filter mip downsampler.
package bfmd_pkg;

    // Configuration register indexes.
    localparam logic [3:0] REG_SOURCE_WIDTH  = 4'd0;
    localparam logic [3:0] REG_SOURCE_HEIGHT = 4'd1;

    // Fixed field widths.
    localparam int DIM_W   = 13;
    localparam int COUNT_W = 12;
    localparam int PIX_W   = 8;
    localparam int PAIR_W  = 9;
    localparam int LANES   = 4;

    // Height limit and reset dimension.
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 13'd4096;
    localparam logic [DIM_W-1:0] DIM_RESET    = 13'd4096;

    // Per-word control decoded from the pixel position.
    typedef struct packed {
        logic accept;     // a word is taken this cycle
        logic hold;       // even column: store the pixel
        logic double_px;  // one-pixel-wide source: pair is twice the pixel
        logic line_wr;    // even row: write the pair sum to the line store
        logic line_rd;    // odd row: read the stored pair sum
        logic emit;       // this word completes a block
        logic use_line;   // block sum takes the stored pair sum
        logic last;       // block is the last of the level
    } ctrl_t;

endpackage

// ===== sv/bfmd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfmd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bfmd_lane.sv =====
// One color channel lane: pair sum, block sum and rounded mean.
module bfmd_lane (
    input  logic                                aclk,
    input  bfmd_pkg::ctrl_t                     ctl,
    input  logic [bfmd_pkg::PIX_W-1:0]          px,
    output logic [bfmd_pkg::PAIR_W-1:0]         pair_out,
    input  logic                                use_line,
    input  logic [bfmd_pkg::PAIR_W-1:0]         line_pair,
    output logic [bfmd_pkg::PIX_W-1:0]          mean
);

    logic [bfmd_pkg::PIX_W-1:0]  held_reg;
    logic [bfmd_pkg::PAIR_W-1:0] pair_next;
    logic [bfmd_pkg::PAIR_W-1:0] pair_reg;
    logic [bfmd_pkg::PAIR_W:0]   block_sum;
    logic [bfmd_pkg::PAIR_W+1:0] rounded;

    // Horizontal pair: held even pixel plus this one, or the lone pixel doubled.
    always_comb begin
        if (ctl.double_px) begin
            pair_next = {px, 1'b0};
        end else begin
            pair_next = {1'b0, held_reg} + {1'b0, px};
        end
    end

    assign pair_out = pair_next;

    // Even-column pixel and the pair of the word in flight.
    always_ff @(posedge aclk) begin
        if (ctl.accept && ctl.hold) begin
            held_reg <= px;
        end
        if (ctl.accept) begin
            pair_reg <= pair_next;
        end
    end

    // Second stage: add the stored row pair (or double for a one-row source), round.
    always_comb begin
        if (use_line) begin
            block_sum = {1'b0, line_pair} + {1'b0, pair_reg};
        end else begin
            block_sum = {pair_reg, 1'b0};
        end
        rounded = {1'b0, block_sum} + 11'd2;
    end

    assign mean = rounded[bfmd_pkg::PIX_W+1:2];

endmodule

// ===== sv/bfmd_ctrl.sv =====
// Source position tracking, configuration registers and per-word decode.
module bfmd_ctrl #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wr_en,
    input  logic [3:0]                               cfg_index,
    input  logic [bfmd_pkg::DIM_W-1:0]               cfg_wdata,
    input  logic                                     accept,
    output bfmd_pkg::ctrl_t                          ctl,
    output logic [((MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] line_addr
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int DW = bfmd_pkg::DIM_W;
    localparam int CW = bfmd_pkg::COUNT_W;

    // Zero acts as one, anything above the line capacity acts as the maximum.
    function automatic logic [DW-1:0] clamp_width(input logic [DW-1:0] v);
        logic [DW-1:0] res;
        res = v;
        if (v == '0) begin
            res = 13'd1;
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            res = 13'(MAX_WIDTH);
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] clamp_height(input logic [DW-1:0] v);
        logic [DW-1:0] res;
        res = v;
        if (v == '0) begin
            res = 13'd1;
        end else if (v > bfmd_pkg::HEIGHT_LIMIT) begin
            res = bfmd_pkg::HEIGHT_LIMIT;
        end
        return res;
    endfunction

    logic [DW-1:0]   width_reg, width_next;
    logic [DW-1:0]   height_reg, height_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   row_reg, row_next;

    logic [DW-1:0]   half_w, half_h, span_w, span_h;
    logic [CW-1:0]   col, row;
    logic [DW-1:0]   col_inc, row_inc;
    logic [CW-2:0]   ox, oy;
    logic            w_one, h_one, col_in, row_in;
    logic            have_pair, pair_ok;

    // Output level size and the span of source columns and rows that are used.
    always_comb begin
        half_w = (width_reg[DW-1:1] == '0) ? 13'd1 : {1'b0, width_reg[DW-1:1]};
        half_h = (height_reg[DW-1:1] == '0) ? 13'd1 : {1'b0, height_reg[DW-1:1]};
        span_w = {half_w[DW-2:0], 1'b0};
        span_h = {half_h[DW-2:0], 1'b0};
        w_one  = (width_reg == 13'd1);
        h_one  = (height_reg == 13'd1);
    end

    // Decode the current position into lane and line store actions.
    always_comb begin
        col       = ({1'b0, col_reg} >= width_reg) ? '0 : col_reg;
        row       = ({1'b0, row_reg} >= height_reg) ? '0 : row_reg;
        col_in    = ({1'b0, col} < span_w);
        row_in    = ({1'b0, row} < span_h);
        have_pair = w_one || (col_in && col[0]);
        ox        = w_one ? '0 : col[CW-1:1];
        oy        = h_one ? '0 : row[CW-1:1];
        pair_ok   = have_pair && (32'(ox) < 32'(LINE_DEPTH));

        ctl.accept    = accept;
        ctl.hold      = !w_one && col_in && !col[0];
        ctl.double_px = w_one;
        ctl.line_wr   = pair_ok && !h_one && row_in && !row[0];
        ctl.line_rd   = pair_ok && !h_one && row_in && row[0];
        ctl.emit      = pair_ok && (h_one || (row_in && row[0]));
        ctl.use_line  = !h_one;
        ctl.last      = ({2'b0, ox} == half_w - 13'd1) && ({2'b0, oy} == half_h - 13'd1);

        line_addr = AW'(ox);
    end

    // Raster position advance with wrap at the end of a row and of the level; a configuration write restarts at zero.
    always_comb begin
        col_inc = {1'b0, col} + 13'd1;
        row_inc = {1'b0, row} + 13'd1;
        col_next    = col_reg;
        row_next    = row_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en && (cfg_index == bfmd_pkg::REG_SOURCE_WIDTH ||
                          cfg_index == bfmd_pkg::REG_SOURCE_HEIGHT)) begin
            if (cfg_index == bfmd_pkg::REG_SOURCE_WIDTH) begin
                width_next = clamp_width(cfg_wdata);
            end else begin
                height_next = clamp_height(cfg_wdata);
            end
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_inc >= width_reg) begin
                col_next = '0;
                row_next = (row_inc >= height_reg) ? '0 : row_inc[CW-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
                row_next = row;
            end
        end
    end

    // Configuration and position registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= clamp_width(bfmd_pkg::DIM_RESET);
            height_reg <= clamp_height(bfmd_pkg::DIM_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ===== sv/box_filter_mip_downsample.sv =====
// Top level: 2x2 box-filter mip downsampler for a raster RGBA8 stream.
// A word that completes a block passes through the block stage register and then the output register to m_tvalid.
// Throughput: one source word per cycle while s_tready is high; the line store takes one access per word.
// While a result waits for m_tready, s_tready stays high only as long as the block stage is empty.
// Reset (synchronous, active low) clears position, handshake state and sets both
// dimensions to 4096; the line store is not cleared, every read follows a write.
module box_filter_mip_downsample #(
    parameter int MAX_WIDTH = 4096,
    parameter int CHANNELS  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    // Source pixel words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_red, in_green, in_blue, in_alpha
    // Result pixel words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic        m_tlast    // last_of_level
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int PW     = bfmd_pkg::PAIR_W;
    localparam int XW     = bfmd_pkg::PIX_W;
    localparam int LINE_W = PW * CHANNELS;

    bfmd_pkg::ctrl_t       ctl;
    logic [AW-1:0]         line_addr;
    logic [LINE_W-1:0]     line_wr_data;
    logic [LINE_W-1:0]     line_rd_data;
    logic [bfmd_pkg::LANES-1:0][XW-1:0] mean;

    logic accept, out_ready;
    logic b_valid_reg, b_valid_next;
    logic b_use_line_reg, b_last_reg;
    logic out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;
    logic out_last_reg;

    // Handshake: the block stage moves on whenever the output register frees up.
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !b_valid_reg || out_ready;
    assign accept    = s_tvalid && s_tready;

    bfmd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .ctl       (ctl),
        .line_addr (line_addr)
    );

    // Channel lanes; channels beyond CHANNELS read as zero.
    for (genvar ch = 0; ch < bfmd_pkg::LANES; ch++) begin : g_lane
        if (ch < CHANNELS) begin : g_used
            logic [PW-1:0] pair;
            bfmd_lane u_lane (
                .aclk      (aclk),
                .ctl       (ctl),
                .px        (s_tdata[XW*ch +: XW]),
                .pair_out  (pair),
                .use_line  (b_use_line_reg),
                .line_pair (line_rd_data[PW*ch +: PW]),
                .mean      (mean[ch])
            );
            assign line_wr_data[PW*ch +: PW] = pair;
        end else begin : g_unused
            assign mean[ch] = '0;
        end
    end

    // Line store of even-row pair sums.
    bfmd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (accept && ctl.line_wr),
        .wr_addr (line_addr),
        .wr_data (line_wr_data),
        .rd_en   (accept && ctl.line_rd),
        .rd_addr (line_addr),
        .rd_data (line_rd_data)
    );

    // Next-state of the block stage and the output register.
    always_comb begin
        b_valid_next   = b_valid_reg && !out_ready;
        if (accept) begin
            b_valid_next = ctl.emit;
        end
        out_valid_next = out_ready ? b_valid_reg : out_valid_reg;
    end

    // Block stage flags and the merged output word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (accept) begin
            b_use_line_reg <= ctl.use_line;
            b_last_reg     <= ctl.last;
        end
        if (out_ready && b_valid_reg) begin
            out_data_reg <= mean;
            out_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/bfmd_checker.sv =====
// Port-level checker for the downsampler, bound to the top level.
module bfmd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [3:0]  cfg_index,
    input logic [12:0] cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result word stays valid.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its data and last flag.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A fresh result is traced back to an accepted source word.
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without a source word");

    // With the output register empty the input side is always open.
    a_ready_free: assert property (@(posedge aclk)
        !m_tvalid |-> s_tready)
        else $error("input blocked with an empty output");

endmodule

bind box_filter_mip_downsample bfmd_checker u_bfmd_checker (.*);
